// ===== rtl/i2cm_pkg.sv =====
// Package for the I2C master bit engine: command codes, phase codes,
// register indexes, reset values and the item type carried by the queue.
// Used by the interfaces and every module of the block.
`timescale 1ns / 1ps

package i2cm_pkg;

   // Command field of an input item.
   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4,
      CMD_ACK   = 3'd5,
      CMD_NACK  = 3'd6
   } cmd_code_type;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_PHASE_TICKS = 1'b0,
      CSR_ACK_TIMEOUT = 1'b1
   } csr_addr_type;

   localparam int TICK_W  = 8;
   localparam int POLL_W  = 16;
   localparam int BYTE_W  = 8;
   localparam int BIT_W   = 4;
   localparam int CSR_W   = 16;
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   localparam logic [TICK_W-1:0] PHASE_TICKS_RST = 8'd5;
   localparam logic [POLL_W-1:0] ACK_TIMEOUT_RST = 16'd100;

   // Bus phases, one-hot.
   typedef enum logic [22:0] {
      PH_IDLE = 23'h000001,
      PH_S0   = 23'h000002,
      PH_S1   = 23'h000004,
      PH_S2   = 23'h000008,
      PH_P0   = 23'h000010,
      PH_P1   = 23'h000020,
      PH_P2   = 23'h000040,
      PH_W0   = 23'h000080,
      PH_W1   = 23'h000100,
      PH_W2   = 23'h000200,
      PH_A0   = 23'h000400,
      PH_A1   = 23'h000800,
      PH_A2   = 23'h001000,
      PH_A3   = 23'h002000,
      PH_R0   = 23'h004000,
      PH_R1   = 23'h008000,
      PH_K0   = 23'h010000,
      PH_K1   = 23'h020000,
      PH_K2   = 23'h040000,
      PH_K3   = 23'h080000,
      PH_N0   = 23'h100000,
      PH_N1   = 23'h200000,
      PH_N2   = 23'h400000
   } phase_type;

   // A classified tick as it waits between the front and the back.
   typedef struct packed {
      cmd_code_type       kind;
      logic [BYTE_W-1:0]  wr_data;
      logic               sda_in;
   } item_type;

endpackage

// ===== rtl/i2cm_if.sv =====
// Channel interfaces of the I2C master bit engine: tick items in,
// results out, and the configuration write channel. Uses i2cm_pkg.
`timescale 1ns / 1ps

interface i2cm_req_if import i2cm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [2:0]        cmd;
   logic [BYTE_W-1:0] wr_data;
   logic              sda_in;

   modport source (output valid, cmd, wr_data, sda_in, input ready);
   modport sink   (input valid, cmd, wr_data, sda_in, output ready);
endinterface

interface i2cm_rsp_if import i2cm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              scl;
   logic              sda_out;
   logic              ready_res;
   logic              done_res;
   logic [BYTE_W-1:0] rd_data;
   logic              ack_error;

   modport source (output valid, scl, sda_out, ready_res, done_res, rd_data, ack_error,
                   input ready);
   modport sink   (input valid, scl, sda_out, ready_res, done_res, rd_data, ack_error,
                   output ready);
endinterface

interface i2cm_csr_if import i2cm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [0:0]       addr;
   logic [CSR_W-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

// ===== rtl/i2cm_front.sv =====
// Front of the I2C master bit engine: takes tick items and classifies the
// command field before the item enters the queue. Uses i2cm_pkg, i2cm_if.
`timescale 1ns / 1ps

module i2cm_front import i2cm_pkg::*; (
   i2cm_req_if.sink   req_ch,
   output logic       push_valid,
   output item_type   push_item,
   input  logic       push_ready
);

   cmd_code_type kind;

   // Codes with no meaning are carried as an empty tick.
   always_comb begin
      unique case (req_ch.cmd)
         3'd1:    kind = CMD_START;
         3'd2:    kind = CMD_STOP;
         3'd3:    kind = CMD_WRITE;
         3'd4:    kind = CMD_READ;
         3'd5:    kind = CMD_ACK;
         3'd6:    kind = CMD_NACK;
         default: kind = CMD_NONE;
      endcase
   end

   // The queue decides whether an item can be taken.
   assign push_valid        = req_ch.valid;
   assign push_item.kind    = kind;
   assign push_item.wr_data = req_ch.wr_data;
   assign push_item.sda_in  = req_ch.sda_in;
   assign req_ch.ready      = push_ready;

endmodule

// ===== rtl/i2cm_fifo.sv =====
// Short queue between the front and the back of the I2C master bit engine.
// Two entries, push and pop in the same cycle. Uses i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_fifo import i2cm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  item_type  push_item,
   output logic      push_ready,
   output logic      pop_valid,
   output item_type  pop_item,
   input  logic      pop_ready
);

   item_type             mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 push, pop;

   assign push_ready = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/i2cm_back.sv =====
// Back of the I2C master bit engine: phase sequencer, bit counter, shift
// register, ack poll counter, configuration registers and the result
// register. Uses i2cm_pkg and i2cm_if.
`timescale 1ns / 1ps

module i2cm_back import i2cm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        pop_valid,
   input  item_type    pop_item,
   output logic        pop_ready,
   i2cm_csr_if.sink    csr_ch,
   i2cm_rsp_if.source  rsp_ch
);

   logic [TICK_W-1:0] phase_ticks_ff, phase_ticks_in;
   logic [POLL_W-1:0] ack_timeout_ff, ack_timeout_in;

   phase_type         state_ff, state_in;
   logic [BIT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [BYTE_W-1:0] shift_ff, shift_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [POLL_W-1:0] poll_ff, poll_in;
   logic              scl_ff, scl_in;
   logic              sda_ff, sda_in;
   logic [BYTE_W-1:0] rd_byte_ff, rd_byte_in;
   logic              err_ff, err_in;

   logic              out_valid_ff, out_valid_in;
   logic              out_ready_res_ff, out_done_ff;

   logic              step;
   logic              done;
   logic              enter_en;
   phase_type         enter_ph;
   logic              finish_en;
   logic              sda_release;
   logic [TICK_W-1:0] hold;
   logic [TICK_W-1:0] tick_inc;
   logic [BIT_W-1:0]  bit_inc;
   logic [1:0]        levels;

   // Line levels set on entry to a phase; msb is the next bit to send.
   function automatic logic [1:0] enter_levels(phase_type ph, logic scl, logic sda,
                                               logic msb);
      logic s;
      logic d;
      s = scl;
      d = sda;
      unique case (ph)
         PH_S0:   begin s = 1'b1; d = 1'b1; end
         PH_S1:   d = 1'b0;
         PH_S2:   s = 1'b0;
         PH_P0:   begin s = 1'b0; d = 1'b0; end
         PH_P1:   s = 1'b1;
         PH_P2:   d = 1'b1;
         PH_W0:   begin s = 1'b0; d = msb; end
         PH_W1:   s = 1'b1;
         PH_W2:   s = 1'b0;
         PH_A0:   d = 1'b1;
         PH_A1:   s = 1'b1;
         PH_A3:   s = 1'b0;
         PH_R0:   begin s = 1'b1; d = 1'b1; end
         PH_R1:   s = 1'b0;
         PH_K0:   begin s = 1'b0; d = 1'b1; end
         PH_K1:   d = 1'b0;
         PH_K2:   s = 1'b1;
         PH_K3:   s = 1'b0;
         PH_N0:   begin s = 1'b0; d = 1'b1; end
         PH_N1:   s = 1'b1;
         PH_N2:   s = 1'b0;
         default: ;
      endcase
      return {s, d};
   endfunction

   // Configuration writes are always taken.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      phase_ticks_in = phase_ticks_ff;
      ack_timeout_in = ack_timeout_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.addr)
            CSR_PHASE_TICKS: phase_ticks_in = csr_ch.data[TICK_W-1:0];
            CSR_ACK_TIMEOUT: ack_timeout_in = csr_ch.data[POLL_W-1:0];
            default: ;
         endcase
      end
   end

   // One queued tick is executed whenever the result register is free.
   assign pop_ready = !out_valid_ff || rsp_ch.ready;
   assign step      = pop_valid && pop_ready;
   assign hold      = (phase_ticks_ff == '0) ? TICK_W'(1) : phase_ticks_ff;
   assign tick_inc  = tick_ff + 1'b1;
   assign bit_inc   = bit_cnt_ff + 1'b1;

   // Sequencer step for one tick.
   always_comb begin
      state_in    = state_ff;
      bit_cnt_in  = bit_cnt_ff;
      shift_in    = shift_ff;
      tick_in     = tick_ff;
      poll_in     = poll_ff;
      rd_byte_in  = rd_byte_ff;
      err_in      = err_ff;
      enter_en    = 1'b0;
      enter_ph    = state_ff;
      finish_en   = 1'b0;
      sda_release = 1'b0;
      done        = 1'b0;

      if (step) begin
         if (state_ff == PH_IDLE) begin
            // New command: set up and enter its first phase.
            unique case (pop_item.kind)
               CMD_START: begin enter_en = 1'b1; enter_ph = PH_S0; end
               CMD_STOP:  begin enter_en = 1'b1; enter_ph = PH_P0; end
               CMD_WRITE: begin
                  shift_in   = pop_item.wr_data;
                  bit_cnt_in = '0;
                  err_in     = 1'b0;
                  enter_en   = 1'b1;
                  enter_ph   = PH_W0;
               end
               CMD_READ: begin
                  shift_in   = '0;
                  bit_cnt_in = '0;
                  enter_en   = 1'b1;
                  enter_ph   = PH_R0;
               end
               CMD_ACK:   begin enter_en = 1'b1; enter_ph = PH_K0; end
               CMD_NACK:  begin enter_en = 1'b1; enter_ph = PH_N0; end
               default: ;
            endcase
         end else if (state_ff == PH_A2) begin
            // Ack poll, one sample per tick.
            if (!pop_item.sda_in) begin
               err_in   = 1'b0;
               enter_en = 1'b1;
               enter_ph = PH_A3;
            end else if (poll_ff >= ack_timeout_ff) begin
               err_in   = 1'b1;
               enter_en = 1'b1;
               enter_ph = PH_P0;
            end else begin
               poll_in = poll_ff + 1'b1;
            end
         end else if (tick_inc >= hold) begin
            // End of a timed phase.
            tick_in = '0;
            unique case (state_ff)
               PH_S0: begin enter_en = 1'b1; enter_ph = PH_S1; end
               PH_S1: begin enter_en = 1'b1; enter_ph = PH_S2; end
               PH_P0: begin enter_en = 1'b1; enter_ph = PH_P1; end
               PH_P1: begin enter_en = 1'b1; enter_ph = PH_P2; end
               PH_W0: begin enter_en = 1'b1; enter_ph = PH_W1; end
               PH_W1: begin enter_en = 1'b1; enter_ph = PH_W2; end
               PH_W2: begin
                  shift_in   = {shift_ff[BYTE_W-2:0], 1'b0};
                  bit_cnt_in = bit_inc;
                  enter_en   = 1'b1;
                  enter_ph   = bit_inc[BIT_W-1] ? PH_A0 : PH_W0;
               end
               PH_A0: begin enter_en = 1'b1; enter_ph = PH_A1; end
               PH_A1: begin enter_en = 1'b1; enter_ph = PH_A2; end
               PH_R0: begin
                  shift_in = {shift_ff[BYTE_W-2:0], pop_item.sda_in};
                  enter_en = 1'b1;
                  enter_ph = PH_R1;
               end
               PH_R1: begin
                  bit_cnt_in = bit_inc;
                  if (bit_inc[BIT_W-1]) begin
                     rd_byte_in = shift_ff;
                     finish_en  = 1'b1;
                  end else begin
                     enter_en = 1'b1;
                     enter_ph = PH_R0;
                  end
               end
               PH_K0: begin enter_en = 1'b1; enter_ph = PH_K1; end
               PH_K1: begin enter_en = 1'b1; enter_ph = PH_K2; end
               PH_K2: begin enter_en = 1'b1; enter_ph = PH_K3; end
               PH_K3: begin sda_release = 1'b1; finish_en = 1'b1; end
               PH_N0: begin enter_en = 1'b1; enter_ph = PH_N1; end
               PH_N1: begin enter_en = 1'b1; enter_ph = PH_N2; end
               default: finish_en = 1'b1;
            endcase
         end else begin
            tick_in = tick_inc;
         end
      end

      // Phase entry and sequence completion.
      levels = {scl_ff, sda_ff};
      if (enter_en) begin
         state_in = enter_ph;
         tick_in  = '0;
         levels   = enter_levels(enter_ph, scl_ff, sda_ff, shift_in[BYTE_W-1]);
         if (enter_ph == PH_A1) begin
            poll_in = '0;
         end
      end
      if (finish_en) begin
         state_in = PH_IDLE;
         tick_in  = '0;
         done     = 1'b1;
      end
      scl_in = levels[1];
      sda_in = levels[0] | sda_release;
   end

   // Result register: holds while the receiver stalls.
   assign out_valid_in = step ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RST;
         ack_timeout_ff <= ACK_TIMEOUT_RST;
         state_ff       <= PH_IDLE;
         bit_cnt_ff     <= '0;
         shift_ff       <= '0;
         tick_ff        <= '0;
         poll_ff        <= '0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         rd_byte_ff     <= '0;
         err_ff         <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         phase_ticks_ff <= phase_ticks_in;
         ack_timeout_ff <= ack_timeout_in;
         state_ff       <= state_in;
         bit_cnt_ff     <= bit_cnt_in;
         shift_ff       <= shift_in;
         tick_ff        <= tick_in;
         poll_ff        <= poll_in;
         scl_ff         <= scl_in;
         sda_ff         <= sda_in;
         rd_byte_ff     <= rd_byte_in;
         err_ff         <= err_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Per-result flags, loaded with each executed tick.
   always_ff @(posedge clock) begin
      if (step) begin
         out_ready_res_ff <= (state_in == PH_IDLE);
         out_done_ff      <= done;
      end
   end

   // The line levels, read byte and error flag are the engine state itself.
   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.scl       = scl_ff;
   assign rsp_ch.sda_out   = sda_ff;
   assign rsp_ch.ready_res = out_ready_res_ff;
   assign rsp_ch.done_res  = out_done_ff;
   assign rsp_ch.rd_data   = rd_byte_ff;
   assign rsp_ch.ack_error = err_ff;

endmodule

// ===== rtl/i2c_master_bit_engine.sv =====
// I2C master bit engine, one bus tick per item.
//
// Channels: req_ch carries one tick (command, byte to write, sampled SDA),
// rsp_ch returns one result per tick (SCL, SDA drive, idle, done, read byte,
// ack error), csr_ch writes phase_ticks (index 0) and ack_timeout (index 1).
// The user must write configuration only while the engine is idle and the
// queue empty; the block itself does not enforce this.
//
// An accepted tick is written into the two-entry queue; the sequencer step
// that executes it loads the result register. One item is taken and one
// result given every cycle while rsp_ch.ready stays high; the sequencer
// executes a whole tick at once, so the queue drains as fast as it fills.
//
// Reset (synchronous, active high) clears the queue and the result register,
// returns the sequencer to idle with both lines released and restores the
// register defaults (5 ticks per phase, 100 ack polls).
// While rsp_ch.ready is low the result holds, the sequencer waits and up to
// two further ticks are queued before req_ch.ready falls.
// Depends on i2cm_pkg, i2cm_if, i2cm_front, i2cm_fifo and i2cm_back.
`timescale 1ns / 1ps

module i2c_master_bit_engine import i2cm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   i2cm_req_if.sink    req_ch,
   i2cm_rsp_if.source  rsp_ch,
   i2cm_csr_if.sink    csr_ch
);

   logic     push_valid;
   logic     push_ready;
   item_type push_item;
   logic     pop_valid;
   logic     pop_ready;
   item_type pop_item;

   // Command classification.
   i2cm_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   // Queue between front and back.
   i2cm_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   // Phase sequencer and result register.
   i2cm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_ready (pop_ready),
      .csr_ch    (csr_ch),
      .rsp_ch    (rsp_ch)
   );

   // A completed sequence always leaves the engine idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.done_res |-> rsp_ch.ready_res)
      else $error("done without idle");

   // An accepted tick is queued for the back at the next edge.
   a_push_queued: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> pop_valid)
      else $error("accepted tick not queued");

   // An executed tick always produces a result.
   a_step_result: assert property (@(posedge clock) disable iff (reset)
      pop_valid && pop_ready |=> rsp_ch.valid)
      else $error("executed tick gave no result");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid && !pop_valid)
      else $error("result or queue entry survived reset");

endmodule

// ===== bench/i2c_master_bit_engine_test.sv =====
// Self-checking bench for the I2C master bit engine: bus ticks are driven in,
// every result is compared with a bit-true copy of the phase sequencer.
// Depends on i2cm_pkg, the channel interfaces and i2c_master_bit_engine.
`timescale 1ns / 1ps

module i2c_master_bit_engine_test;
   import i2cm_pkg::*;

   // The command field is three bits wide; the top code has no meaning.
   localparam logic [2:0] CMD_UNUSED = 3'd7;

   typedef struct packed {
      logic              scl;
      logic              sda_out;
      logic              ready_res;
      logic              done_res;
      logic [BYTE_W-1:0] rd_data;
      logic              ack_error;
   } bus_result_type;

   logic clock;
   logic reset;

   i2cm_req_if req_ch ();
   i2cm_rsp_if rsp_ch ();
   i2cm_csr_if csr_ch ();

   i2c_master_bit_engine uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Shadow copy of the sequencer and its registers.
   phase_type         bus_phase = PH_IDLE;
   logic [BIT_W-1:0]  bits_done = '0;
   logic [BYTE_W-1:0] shifter = '0;
   logic [TICK_W-1:0] tick_cnt = '0;
   logic [POLL_W-1:0] poll_cnt = '0;
   logic              scl_q = 1'b1;
   logic              sda_q = 1'b1;
   logic [BYTE_W-1:0] rd_byte_q = '0;
   logic              ack_err_q = 1'b0;
   logic              done_q = 1'b0;
   logic [TICK_W-1:0] cfg_phase_ticks = PHASE_TICKS_RST;
   logic [POLL_W-1:0] cfg_ack_timeout = ACK_TIMEOUT_RST;

   bus_result_type pending_results[$];
   bus_result_type got_res;
   bus_result_type want_res;

   int src_idle_pct = 0;
   int sink_stall_pct = 0;
   int error_count = 0;
   int ticks_sent = 0;
   int results_checked = 0;
   int cfg_writes = 0;
   int done_seen = 0;
   int timeouts_seen = 0;

   // Entering a phase sets its line levels and restarts the tick counter.
   function void enter_phase(phase_type ph);
      bus_phase = ph;
      tick_cnt = '0;
      case (ph)
         PH_S0: begin sda_q = 1'b1; scl_q = 1'b1; end
         PH_S1: sda_q = 1'b0;
         PH_S2: scl_q = 1'b0;
         PH_P0: begin scl_q = 1'b0; sda_q = 1'b0; end
         PH_P1: scl_q = 1'b1;
         PH_P2: sda_q = 1'b1;
         PH_W0: begin scl_q = 1'b0; sda_q = shifter[BYTE_W-1]; end
         PH_W1: scl_q = 1'b1;
         PH_W2: scl_q = 1'b0;
         PH_A0: sda_q = 1'b1;
         PH_A1: begin scl_q = 1'b1; poll_cnt = '0; end
         PH_A3: scl_q = 1'b0;
         PH_R0: begin sda_q = 1'b1; scl_q = 1'b1; end
         PH_R1: scl_q = 1'b0;
         PH_K0: begin scl_q = 1'b0; sda_q = 1'b1; end
         PH_K1: sda_q = 1'b0;
         PH_K2: scl_q = 1'b1;
         PH_K3: scl_q = 1'b0;
         PH_N0: begin scl_q = 1'b0; sda_q = 1'b1; end
         PH_N1: scl_q = 1'b1;
         PH_N2: scl_q = 1'b0;
         default: ;
      endcase
   endfunction

   function void close_cmd();
      bus_phase = PH_IDLE;
      tick_cnt = '0;
      done_q = 1'b1;
   endfunction

   // Advances the shadow sequencer by one tick and returns the result it gives.
   function bus_result_type predict_tick(logic [2:0] cmd, logic [BYTE_W-1:0] data, logic sda);
      logic [TICK_W-1:0] hold;
      bus_result_type res;
      hold = (cfg_phase_ticks == '0) ? 8'd1 : cfg_phase_ticks;
      done_q = 1'b0;
      if (bus_phase == PH_IDLE) begin
         case (cmd)
            CMD_START: enter_phase(PH_S0);
            CMD_STOP:  enter_phase(PH_P0);
            CMD_WRITE: begin
               shifter = data;
               bits_done = '0;
               ack_err_q = 1'b0;
               enter_phase(PH_W0);
            end
            CMD_READ: begin
               shifter = '0;
               bits_done = '0;
               enter_phase(PH_R0);
            end
            CMD_ACK:  enter_phase(PH_K0);
            CMD_NACK: enter_phase(PH_N0);
            default: ;
         endcase
      end else if (bus_phase == PH_A2) begin
         // The ACK poll takes one sample per tick regardless of the phase length.
         if (!sda) begin
            ack_err_q = 1'b0;
            enter_phase(PH_A3);
         end else if (poll_cnt >= cfg_ack_timeout) begin
            ack_err_q = 1'b1;
            timeouts_seen++;
            enter_phase(PH_P0);
         end else begin
            poll_cnt = poll_cnt + 1'b1;
         end
      end else begin
         tick_cnt = tick_cnt + 1'b1;
         if (tick_cnt >= hold) begin
            tick_cnt = '0;
            case (bus_phase)
               PH_S0: enter_phase(PH_S1);
               PH_S1: enter_phase(PH_S2);
               PH_P0: enter_phase(PH_P1);
               PH_P1: enter_phase(PH_P2);
               PH_W0: enter_phase(PH_W1);
               PH_W1: enter_phase(PH_W2);
               PH_W2: begin
                  shifter = shifter << 1;
                  bits_done = bits_done + 1'b1;
                  if (bits_done >= 4'd8) enter_phase(PH_A0);
                  else enter_phase(PH_W0);
               end
               PH_A0: enter_phase(PH_A1);
               PH_A1: enter_phase(PH_A2);
               PH_R0: begin
                  shifter = {shifter[BYTE_W-2:0], sda};
                  enter_phase(PH_R1);
               end
               PH_R1: begin
                  bits_done = bits_done + 1'b1;
                  if (bits_done >= 4'd8) begin
                     rd_byte_q = shifter;
                     close_cmd();
                  end else begin
                     enter_phase(PH_R0);
                  end
               end
               PH_K0: enter_phase(PH_K1);
               PH_K1: enter_phase(PH_K2);
               PH_K2: enter_phase(PH_K3);
               PH_K3: begin
                  sda_q = 1'b1;
                  close_cmd();
               end
               PH_N0: enter_phase(PH_N1);
               PH_N1: enter_phase(PH_N2);
               default: close_cmd();
            endcase
         end
      end
      if (done_q) done_seen++;
      res.scl = scl_q;
      res.sda_out = sda_q;
      res.ready_res = (bus_phase == PH_IDLE);
      res.done_res = done_q;
      res.rd_data = rd_byte_q;
      res.ack_error = ack_err_q;
      return res;
   endfunction

   function logic pick_sda(int low_pct);
      return ($urandom_range(99) < low_pct) ? 1'b0 : 1'b1;
   endfunction

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The result side stalls at random, decided at each falling edge.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   // Each accepted result is compared with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got_res.scl = rsp_ch.scl;
         got_res.sda_out = rsp_ch.sda_out;
         got_res.ready_res = rsp_ch.ready_res;
         got_res.done_res = rsp_ch.done_res;
         got_res.rd_data = rsp_ch.rd_data;
         got_res.ack_error = rsp_ch.ack_error;
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("Result item with no prediction waiting: scl=%b sda=%b rdy=%b done=%b rd=%02h err=%b",
                        got_res.scl, got_res.sda_out, got_res.ready_res, got_res.done_res,
                        got_res.rd_data, got_res.ack_error);
         end else begin
            want_res = pending_results.pop_front();
            results_checked++;
            if (got_res !== want_res) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("Result %0d mismatch: expected scl=%b sda=%b rdy=%b done=%b rd=%02h err=%b",
                           results_checked, want_res.scl, want_res.sda_out, want_res.ready_res,
                           want_res.done_res, want_res.rd_data, want_res.ack_error);
                  $display("                     actual   scl=%b sda=%b rdy=%b done=%b rd=%02h err=%b",
                           got_res.scl, got_res.sda_out, got_res.ready_res, got_res.done_res,
                           got_res.rd_data, got_res.ack_error);
               end
            end
         end
      end
   end

   // Sends one tick item, with random idle cycles in front of it.
   task automatic send_tick(input logic [2:0] cmd, input logic [BYTE_W-1:0] data,
                            input logic sda);
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.wr_data <= data;
      req_ch.sda_in <= sda;
      do @(posedge clock); while (!req_ch.ready);
      ticks_sent++;
      pending_results.push_back(predict_tick(cmd, data, sda));
   endtask

   // Issues a command and keeps ticking until the engine is idle again.
   // Busy ticks may carry stray commands, which the engine must ignore.
   task automatic run_cmd(input logic [2:0] cmd, input logic [BYTE_W-1:0] data,
                          input int low_pct, input int noise_pct);
      logic [2:0] busy_cmd;
      send_tick(cmd, data, pick_sda(low_pct));
      while (bus_phase != PH_IDLE) begin
         busy_cmd = ($urandom_range(99) < noise_pct) ? 3'($urandom_range(7)) : CMD_NONE;
         send_tick(busy_cmd, 8'($urandom_range(255)), pick_sda(low_pct));
      end
   endtask

   // Stops sending and waits until every predicted result has arrived.
   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_addr_type addr, input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.addr <= addr;
      csr_ch.data <= data;
      do @(posedge clock); while (!csr_ch.ready);
      if (addr == CSR_PHASE_TICKS) cfg_phase_ticks = data[TICK_W-1:0];
      else cfg_ack_timeout = data[POLL_W-1:0];
      cfg_writes++;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Brings the engine to idle, lets it drain, then writes both registers.
   // The upper byte of the phase length write is junk that must be dropped.
   task automatic configure(input logic [TICK_W-1:0] ph_ticks,
                            input logic [POLL_W-1:0] timeout);
      while (bus_phase != PH_IDLE) send_tick(CMD_NONE, 8'($urandom_range(255)), 1'b0);
      drain_results();
      repeat (4) @(posedge clock);
      write_reg(CSR_PHASE_TICKS, {8'($urandom_range(255)), ph_ticks});
      write_reg(CSR_ACK_TIMEOUT, timeout);
   endtask

   // A short transaction under the reset register values.
   task automatic test_reset_defaults();
      src_idle_pct = 0;
      sink_stall_pct = 0;
      run_cmd(CMD_NONE, 8'h00, 50, 0);
      run_cmd(CMD_START, 8'h00, 50, 0);
      run_cmd(CMD_WRITE, 8'hA5, 100, 0);
      run_cmd(CMD_READ, 8'h00, 50, 0);
      run_cmd(CMD_NACK, 8'h00, 50, 0);
      run_cmd(CMD_STOP, 8'h00, 50, 0);
   endtask

   // Every command, ACK and no ACK, fixed read patterns, the unused code
   // and commands offered while the engine is busy.
   task automatic test_each_command();
      src_idle_pct = 37;
      sink_stall_pct = 37;
      configure(8'd1, 16'd3);
      run_cmd(CMD_START, 8'h00, 50, 0);
      run_cmd(CMD_WRITE, 8'hFF, 100, 0);
      run_cmd(CMD_WRITE, 8'h00, 0, 0);
      run_cmd(CMD_READ, 8'h00, 0, 0);
      run_cmd(CMD_ACK, 8'h00, 50, 0);
      run_cmd(CMD_READ, 8'h00, 100, 0);
      run_cmd(CMD_NACK, 8'h00, 50, 0);
      run_cmd(CMD_READ, 8'h00, 50, 0);
      run_cmd(CMD_ACK, 8'h00, 50, 0);
      run_cmd(CMD_WRITE, 8'h5A, 30, 0);
      run_cmd(CMD_STOP, 8'h00, 50, 0);
      run_cmd(CMD_UNUSED, 8'hFF, 50, 0);
      run_cmd(CMD_START, 8'h00, 50, 100);
      run_cmd(CMD_WRITE, 8'hC3, 100, 100);
      run_cmd(CMD_READ, 8'h00, 50, 100);
      run_cmd(CMD_STOP, 8'h00, 50, 100);
   endtask

   // Phase length zero counts as one tick; then a long phase length.
   task automatic test_phase_extremes();
      src_idle_pct = 0;
      sink_stall_pct = 0;
      configure(8'd0, 16'd2);
      run_cmd(CMD_START, 8'h00, 50, 0);
      run_cmd(CMD_WRITE, 8'($urandom_range(255)), 100, 0);
      run_cmd(CMD_READ, 8'h00, 50, 0);
      run_cmd(CMD_NACK, 8'h00, 50, 0);
      run_cmd(CMD_STOP, 8'h00, 50, 0);
      configure(8'd24, 16'd4);
      run_cmd(CMD_NACK, 8'h00, 50, 30);
      run_cmd(CMD_STOP, 8'h00, 50, 0);
   endtask

   // Timeout zero gives up on the first high poll; the largest timeout is
   // answered late but never runs out.
   task automatic test_timeout_extremes();
      src_idle_pct = 0;
      sink_stall_pct = 0;
      configure(8'd1, 16'd0);
      run_cmd(CMD_WRITE, 8'h3C, 0, 0);
      run_cmd(CMD_WRITE, 8'h3C, 100, 0);
      run_cmd(CMD_WRITE, 8'h96, 50, 0);
      configure(8'd1, 16'hFFFF);
      run_cmd(CMD_WRITE, 8'hE7, 2, 0);
      run_cmd(CMD_WRITE, 8'h18, 2, 0);
   endtask

   // Random traffic: mostly framed transactions with random content, some
   // commands in any order, some raw noise, and now and then a full drain.
   task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_ticks);
      int start_ticks;
      int n_bytes;
      int pick;
      int low_pcts[4];
      low_pcts = '{0, 10, 60, 100};
      src_idle_pct = src_pct;
      sink_stall_pct = sink_pct;
      configure(8'($urandom_range(2)), 16'($urandom_range(24)));
      start_ticks = ticks_sent;
      while (ticks_sent - start_ticks < n_ticks) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            run_cmd(CMD_START, 8'h00, 50, 20);
            n_bytes = $urandom_range(1, 3);
            repeat (n_bytes) begin
               if ($urandom_range(1)) begin
                  run_cmd(CMD_WRITE, 8'($urandom_range(255)), low_pcts[$urandom_range(3)], 20);
               end else begin
                  run_cmd(CMD_READ, 8'h00, low_pcts[$urandom_range(3)], 20);
                  run_cmd($urandom_range(1) ? CMD_ACK : CMD_NACK, 8'h00, 50, 20);
               end
            end
            run_cmd(CMD_STOP, 8'h00, 50, 20);
         end else if (pick < 90) begin
            run_cmd(3'($urandom_range(7)), 8'($urandom_range(255)), low_pcts[$urandom_range(3)], 50);
         end else if (pick < 97) begin
            repeat ($urandom_range(1, 8))
               send_tick(3'($urandom_range(7)), 8'($urandom_range(255)), 1'($urandom_range(1)));
         end else begin
            drain_results();
         end
      end
   endtask

   // Reset, directed checks, random phases, then the final drain and verdict.
   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_NONE;
      req_ch.wr_data = '0;
      req_ch.sda_in = 1'b1;
      csr_ch.valid = 1'b0;
      csr_ch.addr = CSR_PHASE_TICKS;
      csr_ch.data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_each_command();
      test_phase_extremes();
      test_timeout_extremes();
      test_random_traffic(0, 0, 60);
      test_random_traffic(70, 0, 60);
      test_random_traffic(0, 70, 60);
      test_random_traffic(37, 37, 60);

      drain_results();
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0) begin
         error_count++;
         $display("%0d predicted results never arrived", pending_results.size());
      end

      $display("Run covered %0d tick items and %0d register writes; %0d results checked.",
               ticks_sent, cfg_writes, results_checked);
      $display("Commands completed: %0d, ack timeouts: %0d, mismatches: %0d.",
               done_seen, timeouts_seen, error_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
